@@ hdl/fdc_pkg.sv @@
// Shared types, codes and the CRC-32 byte step for the frame deframer.
package fdc_pkg;

    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
    localparam logic [15:0] MAX_PLEN_RESET = 16'd4096;

    localparam int MSGID_BYTES = 4;
    localparam int TSTAMP_BYTES = 8;
    localparam int PLEN_BYTES = 4;
    localparam int CRC_BYTES = 4;

    typedef enum logic [1:0] {
        KIND_ID_BYTE      = 2'd0,
        KIND_PAYLOAD_BYTE = 2'd1,
        KIND_SUMMARY      = 2'd2
    } item_kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CRC_ERR   = 3'd1,
        ST_EMPTY_ID  = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_TRUNCATED = 3'd4
    } frame_status_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        item_kind_t    item_kind;
        logic [7:0]    data_byte;
        logic [31:0]   msg_ident;
        logic [7:0]    message_type;
        logic [7:0]    id_length;
        logic [63:0]   timestamp_ms;
        logic [15:0]   payload_length;
        frame_status_t frame_status;
    } result_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ hdl/frame_deframer_crc32_check.sv @@
// An accepted input beat is registered in the input register, its result in the result register.
// Throughput: one byte per cycle while no byte with a result meets a stalled output;
// the CRC-32 byte step and field capture run combinationally between the two registers.
// A frame yields its id/payload beats and one summary (a cut frame's at the next start), no extra gaps.
// Reset (aresetn low, synchronous): parser idle, CRC preset, limit back to 4096.
module frame_deframer_crc32_check (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] byte_value
    input  logic          s_axis_tuser,   // [0] frame_start
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [7:0] data_byte, [39:8] msg_ident, [47:40] message_type, [55:48] id_length,
    // [119:56] timestamp_ms, [135:120] payload_length, [138:136] frame_status
    output logic [143:0]  m_axis_tdata,
    output logic [1:0]    m_axis_tuser,   // [1:0] item_kind
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data
);

    logic              in_valid_reg;
    fdc_pkg::in_item_t in_item_reg;
    logic [15:0]       max_len_reg;
    logic              proc;
    logic              res_valid;
    logic              out_free;
    fdc_pkg::result_t  res;
    fdc_pkg::result_t  m_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= fdc_pkg::MAX_PLEN_RESET;
        end else if (cfg_valid) begin
            max_len_reg <= cfg_data;
        end
    end

    // byte without a result moves on even when the output is stalled
    assign proc = in_valid_reg && (out_free || !res_valid);
    assign s_axis_tready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.byte_value  <= s_axis_tdata;
            in_item_reg.frame_start <= s_axis_tuser;
        end
    end

    fdc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .proc      (proc),
        .item      (in_item_reg),
        .max_len   (max_len_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    fdc_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (proc && res_valid),
        .load_data (res),
        .m_ready   (m_axis_tready),
        .m_valid   (m_axis_tvalid),
        .out_free  (out_free),
        .m_data    (m_res)
    );

    assign m_axis_tuser = m_res.item_kind;
    assign m_axis_tdata = {5'd0, m_res.frame_status, m_res.payload_length,
                           m_res.timestamp_ms, m_res.id_length, m_res.message_type,
                           m_res.msg_ident, m_res.data_byte};

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proc |=> in_valid_reg && $stable(in_item_reg))
        else $error("input register lost a pending beat");

    a_byte_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != fdc_pkg::KIND_SUMMARY |->
        m_axis_tdata[138:136] == fdc_pkg::ST_OK &&
        (m_axis_tuser == fdc_pkg::KIND_ID_BYTE || m_axis_tuser == fdc_pkg::KIND_PAYLOAD_BYTE))
        else $error("byte beat carries a status or bad kind");

    a_ok_has_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == fdc_pkg::KIND_SUMMARY &&
        m_axis_tdata[138:136] == fdc_pkg::ST_OK |-> m_axis_tdata[55:48] != 8'd0)
        else $error("ok summary with empty id");

    a_summary_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == fdc_pkg::KIND_SUMMARY |->
        m_axis_tdata[7:0] == 8'd0)
        else $error("summary beat carries a data byte");

endmodule

@@ hdl/fdc_parser.sv @@
// Frame parser: phase tracking, field capture, CRC accumulation and result build.
module fdc_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              proc,
    input  fdc_pkg::in_item_t item,
    input  logic [15:0]       max_len,
    output logic              res_valid,
    output fdc_pkg::result_t  res
);

    typedef enum logic [8:0] {
        PH_IDLE    = 9'b000000001,
        PH_MSGID   = 9'b000000010,
        PH_TYPE    = 9'b000000100,
        PH_IDLEN   = 9'b000001000,
        PH_IDBYTES = 9'b000010000,
        PH_TSTAMP  = 9'b000100000,
        PH_PLEN    = 9'b001000000,
        PH_PAYLOAD = 9'b010000000,
        PH_CRC     = 9'b100000000
    } phase_t;

    phase_t      phase_reg, phase_next, ph;
    logic [7:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] id_reg, id_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  idlen_reg, idlen_next;
    logic [63:0] ts_reg, ts_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic [8:0]  cnt_inc;
    logic [7:0]  b;

    assign b = item.byte_value;

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        crc_next   = crc_reg;
        id_next    = id_reg;
        type_next  = type_reg;
        idlen_next = idlen_reg;
        ts_next    = ts_reg;
        len_next   = len_reg;
        rcrc_next  = rcrc_reg;
        res_valid  = 1'b0;
        res        = '0;
        ph         = phase_reg;

        // truncated summary uses the old frame's fields
        res.item_kind      = fdc_pkg::KIND_SUMMARY;
        res.msg_ident      = id_reg;
        res.message_type   = type_reg;
        res.id_length      = idlen_reg;
        res.timestamp_ms   = ts_reg;
        res.payload_length = (|len_reg[31:16]) ? 16'hFFFF : len_reg[15:0];
        res.frame_status   = fdc_pkg::ST_TRUNCATED;

        if (item.frame_start) begin
            res_valid  = (phase_reg != PH_IDLE);
            ph         = PH_MSGID;
            cnt_next   = '0;
            rem_next   = '0;
            crc_next   = fdc_pkg::CRC_INIT;
            id_next    = '0;
            type_next  = '0;
            idlen_next = '0;
            ts_next    = '0;
            len_next   = '0;
            rcrc_next  = '0;
        end
        phase_next = ph;
        cnt_inc = {1'b0, cnt_next} + 9'd1;

        case (ph)
            PH_IDLE: begin
            end
            PH_MSGID: begin
                id_next  = {id_next[23:0], b};
                crc_next = fdc_pkg::crc_byte(crc_next, b);
                cnt_next = cnt_inc[7:0];
                if (cnt_inc >= 9'(fdc_pkg::MSGID_BYTES)) begin
                    cnt_next   = '0;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: begin
                type_next  = b;
                crc_next   = fdc_pkg::crc_byte(crc_next, b);
                phase_next = PH_IDLEN;
            end
            PH_IDLEN: begin
                idlen_next = b;
                crc_next   = fdc_pkg::crc_byte(crc_next, b);
                cnt_next   = '0;
                phase_next = (b == 8'd0) ? PH_TSTAMP : PH_IDBYTES;
            end
            PH_IDBYTES: begin
                crc_next  = fdc_pkg::crc_byte(crc_next, b);
                res_valid = 1'b1;
                res.item_kind    = fdc_pkg::KIND_ID_BYTE;
                res.data_byte    = b;
                res.frame_status = fdc_pkg::ST_OK;
                cnt_next = cnt_inc[7:0];
                if (cnt_inc >= {1'b0, idlen_next}) begin
                    cnt_next   = '0;
                    phase_next = PH_TSTAMP;
                end
            end
            PH_TSTAMP: begin
                ts_next  = {ts_next[55:0], b};
                cnt_next = cnt_inc[7:0];
                if (cnt_inc >= 9'(fdc_pkg::TSTAMP_BYTES)) begin
                    cnt_next   = '0;
                    phase_next = PH_PLEN;
                end
            end
            PH_PLEN: begin
                len_next = {len_next[23:0], b};
                cnt_next = cnt_inc[7:0];
                if (cnt_inc >= 9'(fdc_pkg::PLEN_BYTES)) begin
                    cnt_next = '0;
                    if (len_next > {16'd0, max_len}) begin
                        res_valid = 1'b1;
                        res.frame_status = fdc_pkg::ST_TOO_LONG;
                        phase_next = PH_IDLE;
                    end else if (len_next == 32'd0) begin
                        phase_next = PH_CRC;
                    end else begin
                        rem_next   = len_next[15:0];
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                crc_next  = fdc_pkg::crc_byte(crc_next, b);
                res_valid = 1'b1;
                res.item_kind    = fdc_pkg::KIND_PAYLOAD_BYTE;
                res.data_byte    = b;
                res.frame_status = fdc_pkg::ST_OK;
                rem_next = rem_next - 16'd1;
                if (rem_next == 16'd0) begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC: begin
                rcrc_next = {rcrc_next[23:0], b};
                cnt_next  = cnt_inc[7:0];
                if (cnt_inc >= 9'(fdc_pkg::CRC_BYTES)) begin
                    cnt_next  = '0;
                    res_valid = 1'b1;
                    if (~crc_next != rcrc_next) begin
                        res.frame_status = fdc_pkg::ST_CRC_ERR;
                    end else if (idlen_next == 8'd0) begin
                        res.frame_status = fdc_pkg::ST_EMPTY_ID;
                    end else begin
                        res.frame_status = fdc_pkg::ST_OK;
                    end
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // fields received so far in the current frame
        if (ph != PH_IDLE) begin
            if (!(item.frame_start && res.frame_status == fdc_pkg::ST_TRUNCATED
                  && res.item_kind == fdc_pkg::KIND_SUMMARY)) begin
                res.msg_ident      = id_next;
                res.message_type   = type_next;
                res.id_length      = idlen_next;
                res.timestamp_ms   = ts_next;
                res.payload_length = (|len_next[31:16]) ? 16'hFFFF : len_next[15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            crc_reg   <= fdc_pkg::CRC_INIT;
            id_reg    <= '0;
            type_reg  <= '0;
            idlen_reg <= '0;
            ts_reg    <= '0;
            len_reg   <= '0;
            rcrc_reg  <= '0;
        end else if (proc) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            rem_reg   <= rem_next;
            crc_reg   <= crc_next;
            id_reg    <= id_next;
            type_reg  <= type_next;
            idlen_reg <= idlen_next;
            ts_reg    <= ts_next;
            len_reg   <= len_next;
            rcrc_reg  <= rcrc_next;
        end
    end

endmodule

@@ hdl/fdc_out_reg.sv @@
// Result register holding one beat for the output channel.
module fdc_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  fdc_pkg::result_t load_data,
    input  logic             m_ready,
    output logic             m_valid,
    output logic             out_free,
    output fdc_pkg::result_t m_data
);

    logic             valid_reg;
    fdc_pkg::result_t data_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

@@ tb/sv/fdc_frame_checker.sv @@
// Frame deframer checker: tracks the parser state, predicts result beats and compares them.
module fdc_frame_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,
    input  logic          s_axis_tuser,
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [143:0]  m_axis_tdata,
    input  logic [1:0]    m_axis_tuser,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [15:0]   cfg_data,
    output int            fail_count,
    output int            results_due
);

    typedef enum logic [3:0] {
        P_IDLE, P_MSGID, P_TYPE, P_IDLEN, P_IDBYTES, P_TSTAMP, P_PLEN, P_PAYLOAD, P_CRC
    } parse_phase_t;

    parse_phase_t phase;
    logic [7:0]   field_cnt;
    logic [15:0]  payload_left;
    logic [31:0]  running_crc;
    logic [31:0]  msg_id;
    logic [7:0]   msg_type;
    logic [7:0]   id_len;
    logic [63:0]  stamp;
    logic [31:0]  plen;
    logic [31:0]  rx_crc;
    logic [15:0]  plen_limit;

    fdc_pkg::result_t pending_results[$];

    initial begin
        fail_count  = 0;
        results_due = 0;
    end

    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ fdc_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic fdc_pkg::result_t snapshot(input fdc_pkg::item_kind_t k,
                                                  input logic [7:0] d,
                                                  input fdc_pkg::frame_status_t st);
        fdc_pkg::result_t r;
        r.item_kind      = k;
        r.data_byte      = d;
        r.msg_ident      = msg_id;
        r.message_type   = msg_type;
        r.id_length      = id_len;
        r.timestamp_ms   = stamp;
        r.payload_length = (plen > 32'h0000_FFFF) ? 16'hFFFF : plen[15:0];
        r.frame_status   = st;
        return r;
    endfunction

    function automatic void queue_result(input fdc_pkg::result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    task automatic clear_frame();
        field_cnt    = '0;
        payload_left = '0;
        running_crc  = fdc_pkg::CRC_INIT;
        msg_id       = '0;
        msg_type     = '0;
        id_len       = '0;
        stamp        = '0;
        plen         = '0;
        rx_crc       = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic start);
        fdc_pkg::frame_status_t st;
        if (start) begin
            if (phase != P_IDLE)
                queue_result(snapshot(fdc_pkg::KIND_SUMMARY, 8'd0, fdc_pkg::ST_TRUNCATED));
            clear_frame();
            phase = P_MSGID;
        end
        case (phase)
            P_MSGID: begin
                msg_id      = {msg_id[23:0], b};
                running_crc = crc_update(running_crc, b);
                field_cnt++;
                if (field_cnt >= fdc_pkg::MSGID_BYTES) begin
                    field_cnt = '0;
                    phase     = P_TYPE;
                end
            end
            P_TYPE: begin
                msg_type    = b;
                running_crc = crc_update(running_crc, b);
                phase       = P_IDLEN;
            end
            P_IDLEN: begin
                id_len      = b;
                running_crc = crc_update(running_crc, b);
                field_cnt   = '0;
                phase       = (b == 8'd0) ? P_TSTAMP : P_IDBYTES;
            end
            P_IDBYTES: begin
                running_crc = crc_update(running_crc, b);
                queue_result(snapshot(fdc_pkg::KIND_ID_BYTE, b, fdc_pkg::ST_OK));
                field_cnt++;
                if (field_cnt >= id_len) begin
                    field_cnt = '0;
                    phase     = P_TSTAMP;
                end
            end
            P_TSTAMP: begin
                stamp = {stamp[55:0], b};
                field_cnt++;
                if (field_cnt >= fdc_pkg::TSTAMP_BYTES) begin
                    field_cnt = '0;
                    phase     = P_PLEN;
                end
            end
            P_PLEN: begin
                plen = {plen[23:0], b};
                field_cnt++;
                if (field_cnt >= fdc_pkg::PLEN_BYTES) begin
                    field_cnt = '0;
                    if (plen > {16'd0, plen_limit}) begin
                        // rejected right after the length; rest of frame is dropped
                        queue_result(snapshot(fdc_pkg::KIND_SUMMARY, 8'd0,
                                              fdc_pkg::ST_TOO_LONG));
                        phase = P_IDLE;
                    end else if (plen == 32'd0) begin
                        phase = P_CRC;
                    end else begin
                        payload_left = plen[15:0];
                        phase        = P_PAYLOAD;
                    end
                end
            end
            P_PAYLOAD: begin
                running_crc = crc_update(running_crc, b);
                queue_result(snapshot(fdc_pkg::KIND_PAYLOAD_BYTE, b, fdc_pkg::ST_OK));
                payload_left--;
                if (payload_left == 16'd0)
                    phase = P_CRC;
            end
            P_CRC: begin
                rx_crc = {rx_crc[23:0], b};
                field_cnt++;
                if (field_cnt >= fdc_pkg::CRC_BYTES) begin
                    field_cnt = '0;
                    // a bad CRC wins over an empty id
                    if (~running_crc != rx_crc)
                        st = fdc_pkg::ST_CRC_ERR;
                    else if (id_len == 8'd0)
                        st = fdc_pkg::ST_EMPTY_ID;
                    else
                        st = fdc_pkg::ST_OK;
                    queue_result(snapshot(fdc_pkg::KIND_SUMMARY, 8'd0, st));
                    phase = P_IDLE;
                end
            end
            default: ;  // idle and no frame start: byte is dropped
        endcase
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic check_beat();
        fdc_pkg::result_t got;
        fdc_pkg::result_t want;
        got.item_kind      = fdc_pkg::item_kind_t'(m_axis_tuser);
        got.data_byte      = m_axis_tdata[7:0];
        got.msg_ident      = m_axis_tdata[39:8];
        got.message_type   = m_axis_tdata[47:40];
        got.id_length      = m_axis_tdata[55:48];
        got.timestamp_ms   = m_axis_tdata[119:56];
        got.payload_length = m_axis_tdata[135:120];
        got.frame_status   = fdc_pkg::frame_status_t'(m_axis_tdata[138:136]);
        if (pending_results.size() == 0) begin
            report("result beat with nothing expected, item_kind", 64'(got.item_kind), 64'd0);
        end else begin
            want = pending_results.pop_front();
            if (got.item_kind !== want.item_kind)
                report("item_kind", 64'(got.item_kind), 64'(want.item_kind));
            if (got.data_byte !== want.data_byte)
                report("data_byte", 64'(got.data_byte), 64'(want.data_byte));
            if (got.msg_ident !== want.msg_ident)
                report("msg_ident", 64'(got.msg_ident), 64'(want.msg_ident));
            if (got.message_type !== want.message_type)
                report("message_type", 64'(got.message_type), 64'(want.message_type));
            if (got.id_length !== want.id_length)
                report("id_length", 64'(got.id_length), 64'(want.id_length));
            if (got.timestamp_ms !== want.timestamp_ms)
                report("timestamp_ms", got.timestamp_ms, want.timestamp_ms);
            if (got.payload_length !== want.payload_length)
                report("payload_length", 64'(got.payload_length), 64'(want.payload_length));
            if (got.frame_status !== want.frame_status)
                report("frame_status", 64'(got.frame_status), 64'(want.frame_status));
        end
        if (m_axis_tdata[143:139] !== 5'd0)
            report("tdata fill bits", 64'(m_axis_tdata[143:139]), 64'd0);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_frame();
            phase      = P_IDLE;
            plen_limit = fdc_pkg::MAX_PLEN_RESET;
            pending_results.delete();
        end else begin
            // drain first: a beat leaving now never belongs to a byte entering now
            if (m_axis_tvalid && m_axis_tready)
                check_beat();
            if (cfg_valid && cfg_ready)
                plen_limit = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                parse_byte(s_axis_tdata, s_axis_tuser);
        end
        results_due = pending_results.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the frame deframer: clock, reset, frame stimulus, stalls and verdict.
module tb_top;

    localparam int STALL_LIMIT     = 500;
    localparam int ITEMS_PER_PHASE = 200;

    logic          aclk;
    logic          aresetn       = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [7:0]    s_axis_tdata  = 8'd0;
    logic          s_axis_tuser  = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [143:0]  m_axis_tdata;
    logic [1:0]    m_axis_tuser;
    logic          cfg_valid     = 1'b0;
    logic          cfg_ready;
    logic [15:0]   cfg_data      = 16'd0;

    int            fail_count;
    int            results_due;

    bit            quiet      = 1'b0;
    int            stall_left = 0;
    int            dead_cycles = 0;
    int            frame_items = 0;
    logic [15:0]   cur_limit  = fdc_pkg::MAX_PLEN_RESET;
    logic [7:0]    frame_q[$];

    frame_deframer_crc32_check DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    fdc_frame_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .results_due   (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // result-side back-pressure in bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(1, 9) - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                dead_cycles = 0;
            else
                dead_cycles++;
            if (dead_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus needs valid CRCs of its own
    function automatic logic [31:0] stim_crc(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ fdc_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    function automatic logic [7:0] pick(input int fill);
        return (fill < 0) ? 8'($urandom) : fill[7:0];
    endfunction

    function automatic void add_byte(input logic [7:0] v);
        frame_q.insert(frame_q.size(), v);
    endfunction

    // one beat on the byte input; caller sits at a falling edge
    task automatic push_beat(input logic [7:0] b, input logic st);
        if (!quiet && $urandom_range(0, 11) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // fill < 0 gives random content, otherwise every free byte takes that value
    task automatic build_frame(input int id_bytes, input logic [31:0] len_field,
                               input bit bad_crc, input int fill);
        logic [31:0] crc;
        logic [31:0] id_word;
        logic [63:0] stamp;
        logic [7:0]  b;
        frame_q.delete();
        crc     = fdc_pkg::CRC_INIT;
        id_word = {pick(fill), pick(fill), pick(fill), pick(fill)};
        for (int i = 0; i < fdc_pkg::MSGID_BYTES; i++) begin
            b = id_word[31 - 8*i -: 8];
            add_byte(b);
            crc = stim_crc(crc, b);
        end
        b = pick(fill);
        add_byte(b);
        crc = stim_crc(crc, b);
        b = id_bytes[7:0];
        add_byte(b);
        crc = stim_crc(crc, b);
        for (int i = 0; i < id_bytes; i++) begin
            b = pick(fill);
            add_byte(b);
            crc = stim_crc(crc, b);
        end
        stamp = {pick(fill), pick(fill), pick(fill), pick(fill),
                 pick(fill), pick(fill), pick(fill), pick(fill)};
        for (int i = 0; i < fdc_pkg::TSTAMP_BYTES; i++)
            add_byte(stamp[63 - 8*i -: 8]);
        for (int i = 0; i < fdc_pkg::PLEN_BYTES; i++)
            add_byte(len_field[31 - 8*i -: 8]);
        if (len_field > {16'd0, cur_limit}) begin
            // trailing bytes after a rejected length land on an idle parser
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
        end else begin
            for (int i = 0; i < int'(len_field); i++) begin
                b = pick(fill);
                add_byte(b);
                crc = stim_crc(crc, b);
            end
            crc = ~crc;
            if (bad_crc)
                crc ^= 32'd1 << $urandom_range(0, 31);
            for (int i = 0; i < fdc_pkg::CRC_BYTES; i++)
                add_byte(crc[31 - 8*i -: 8]);
        end
    endtask

    // cut < 0 sends the whole frame, otherwise only its first cut bytes
    task automatic send_frame(input int cut);
        int n;
        n = (cut < 0 || cut > frame_q.size()) ? frame_q.size() : cut;
        for (int i = 0; i < n; i++)
            push_beat(frame_q[i], i == 0);
        frame_items += n;
    endtask

    task automatic write_limit(input logic [15:0] v);
        s_axis_tvalid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_limit = v;
    endtask

    task automatic random_traffic();
        int          sel;
        int          id_bytes;
        int          cap;
        logic [31:0] len_field;
        sel      = $urandom_range(0, 99);
        id_bytes = ($urandom_range(0, 49) == 0) ? $urandom_range(9, 255) : $urandom_range(0, 8);
        cap      = (cur_limit < 16) ? int'(cur_limit) : 16;
        len_field = $urandom_range(0, cap);
        if ($urandom_range(0, 19) == 0 && cur_limit <= 300)
            len_field = {16'd0, cur_limit};
        if (sel < 70) begin
            build_frame(id_bytes, len_field, $urandom_range(0, 6) == 0, -1);
            send_frame(-1);
        end else if (sel < 80) begin
            len_field = $urandom_range(0, 1) ? {16'd0, cur_limit} + 1 + $urandom_range(0, 3)
                                             : ($urandom | 32'h0001_0000);
            build_frame(id_bytes, len_field, 1'b0, -1);
            send_frame(-1);
        end else if (sel < 92) begin
            build_frame(id_bytes, len_field, 1'b0, -1);
            send_frame($urandom_range(1, frame_q.size() - 1));
        end else begin
            repeat ($urandom_range(1, 4)) push_beat(8'($urandom), $urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        logic [15:0] limits[5];
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed frames at the reset limit
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        build_frame(1, 32'd1, 1'b0, 8'hFF);
        send_frame(-1);
        build_frame(0, 32'd0, 1'b0, 8'h00);
        send_frame(-1);
        build_frame(0, 32'd0, 1'b1, -1);
        send_frame(-1);
        build_frame(2, {16'd0, fdc_pkg::MAX_PLEN_RESET} + 1, 1'b0, -1);
        send_frame(-1);
        build_frame(1, 32'hFFFF_FFFF, 1'b0, -1);
        send_frame(-1);
        build_frame(3, 32'd5, 1'b0, -1);
        send_frame(8);
        build_frame(2, 32'd2, 1'b0, -1);
        send_frame(frame_q.size() - 2);
        build_frame(1, 32'd1, 1'b0, -1);
        send_frame(1);
        build_frame(4, 32'd3, 1'b0, -1);
        send_frame(-1);

        limits[0] = 16'hFFFF;
        limits[1] = 16'd0;
        limits[2] = 16'd7;
        limits[3] = 16'($urandom_range(0, 65535));
        limits[4] = fdc_pkg::MAX_PLEN_RESET;
        for (int p = 0; p < 5; p++) begin
            write_limit(limits[p]);
            if (p == 4)
                quiet = 1'b1;
            frame_items = 0;
            while (frame_items < ITEMS_PER_PHASE)
                random_traffic();
        end

        s_axis_tvalid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/fdc_pkg.sv
hdl/fdc_parser.sv
hdl/fdc_out_reg.sv
hdl/frame_deframer_crc32_check.sv
tb/sv/fdc_frame_checker.sv
tb/sv/tb_top.sv
